FILE: hw/rtl/wsv_pkg.sv
// wsv_pkg: shared widths, codes and types of the weighted status vote core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wsv_pkg;

	localparam int NUM_DET   = 4;
	localparam int SLOT_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int TIME_W    = 48;
	localparam int WEIGHT_W  = 16;
	localparam int SCORE_W   = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_3 = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_MOV  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_POSSIBLY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_MOVING   = 2'd3;

	localparam logic [CFG_DAT_W-1:0] WEIGHTS_RST = 64'h0001_0001_0001_0001;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TIME_W-1:0]   stamp;
	} entry_t;

	typedef struct packed {
		logic              clr;
		logic              upd_latest;
		logic              upd_score;
		logic [SLOT_W-1:0] slot;
	} acc_ctl_t;

	typedef logic [NUM_DET-1:0][WEIGHT_W-1:0] weights_t;
	typedef logic [NUM_DET-1:0][TIME_W-1:0]   stale_t;
	typedef logic [3:1][SCORE_W-1:0]          scores_t;
	typedef logic [3:1]                       voted_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wsv_store.sv
// wsv_store: four-entry report memory with registered read
// entries never written read as invalid status at time zero; uses wsv_pkg
`timescale 1ns / 1ps
`default_nettype none
module wsv_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [wsv_pkg::SLOT_W-1:0]  wr_addr,
	input  wire wsv_pkg::entry_t             wr_data,
	input  wire logic                        rd_en,
	input  wire logic [wsv_pkg::SLOT_W-1:0]  rd_addr,
	output wsv_pkg::entry_t                  rd_data
);

	wsv_pkg::entry_t                 mem [wsv_pkg::NUM_DET];
	logic [wsv_pkg::NUM_DET-1:0]     valid_q;
	wsv_pkg::entry_t                 rd_raw_s1;
	logic                            rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_raw_s1 : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/wsv_accum.sv
// wsv_accum: latest-time sweep and weighted score sweep over read-back entries
// driven by the sequencer through acc_ctl_t; uses wsv_pkg
`timescale 1ns / 1ps
`default_nettype none
module wsv_accum (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire wsv_pkg::acc_ctl_t           ctl,
	input  wire wsv_pkg::entry_t             rd_data,
	input  wire logic [wsv_pkg::NUM_DET-1:0] enable_mask,
	input  wire wsv_pkg::weights_t           weights,
	input  wire wsv_pkg::stale_t             stale_limit,
	output wsv_pkg::scores_t                 scores,
	output wsv_pkg::voted_t                  voted
);

	logic                         any_q;
	logic [wsv_pkg::TIME_W-1:0]   latest_q;
	wsv_pkg::scores_t             score_q;
	wsv_pkg::voted_t              voted_q;
	logic                         slot_en;
	logic [wsv_pkg::TIME_W-1:0]   age;
	logic                         vote;

	assign slot_en = enable_mask[ctl.slot];
	assign age     = latest_q - rd_data.stamp;
	assign vote    = ctl.upd_score && slot_en && (rd_data.status != wsv_pkg::STAT_INVALID)
		&& (age <= stale_limit[ctl.slot]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q    <= 1'b0;
			latest_q <= '0;
			score_q  <= '0;
			voted_q  <= '0;
		end else if (ctl.clr) begin
			any_q    <= 1'b0;
			latest_q <= '0;
			score_q  <= '0;
			voted_q  <= '0;
		end else begin
			if (ctl.upd_latest && slot_en) begin
				any_q <= 1'b1;
				if (!any_q || (rd_data.stamp > latest_q)) begin
					latest_q <= rd_data.stamp;
				end
			end
			for (int s = 1; s < 4; s++) begin
				if (vote && (rd_data.status == wsv_pkg::STATUS_W'(s))) begin
					score_q[s] <= score_q[s] + wsv_pkg::SCORE_W'(weights[ctl.slot]);
					voted_q[s] <= 1'b1;
				end
			end
		end
	end

	assign scores = score_q;
	assign voted  = voted_q;

endmodule
`default_nettype wire

FILE: hw/rtl/wsv_decide.sv
// wsv_decide: two-stage pick of the top status and the one-percent near-tie test
// uses wsv_pkg
`timescale 1ns / 1ps
`default_nettype none
module wsv_decide (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire wsv_pkg::scores_t              scores,
	input  wire wsv_pkg::voted_t               voted,
	output logic                               out_valid,
	output logic [wsv_pkg::STATUS_W-1:0]       out_status,
	output logic [wsv_pkg::SCORE_W-1:0]        out_score
);

	localparam int PROD_W = wsv_pkg::SCORE_W + 7;

	logic [wsv_pkg::STATUS_W-1:0] top_c;
	logic [wsv_pkg::SCORE_W-1:0]  best_c;
	logic                         near_c;

	logic                         go_s1;
	logic [wsv_pkg::STATUS_W-1:0] top_s1;
	logic [wsv_pkg::SCORE_W-1:0]  max_s1;
	wsv_pkg::scores_t             scores_s1;
	wsv_pkg::voted_t              voted_s1;

	logic                         done_s2;
	logic [wsv_pkg::STATUS_W-1:0] status_s2;
	logic [wsv_pkg::SCORE_W-1:0]  score_s2;

	// lowest code wins on equal scores
	always_comb begin
		top_c  = wsv_pkg::STAT_INVALID;
		best_c = '0;
		for (int s = 1; s < 4; s++) begin
			if (voted[s] && ((top_c == wsv_pkg::STAT_INVALID) || (scores[s] > best_c))) begin
				top_c  = wsv_pkg::STATUS_W'(s);
				best_c = scores[s];
			end
		end
	end

	// 100 * (max - s) < max
	always_comb begin
		logic [wsv_pkg::SCORE_W-1:0] diff;
		logic [PROD_W-1:0]           prod;
		near_c = 1'b0;
		diff   = '0;
		prod   = '0;
		for (int s = 1; s < 4; s++) begin
			diff = max_s1 - scores_s1[s];
			prod = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
			if ((top_s1 != wsv_pkg::STATUS_W'(s)) && voted_s1[s]
				&& (prod < PROD_W'(max_s1))) begin
				near_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			top_s1    <= top_c;
			max_s1    <= best_c;
			scores_s1 <= scores;
			voted_s1  <= voted;
		end
		if (go_s1) begin
			if (top_s1 == wsv_pkg::STAT_INVALID) begin
				status_s2 <= wsv_pkg::STAT_INVALID;
				score_s2  <= '0;
			end else begin
				status_s2 <= near_c ? wsv_pkg::STAT_POSSIBLY : top_s1;
				score_s2  <= max_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1   <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			go_s1   <= go;
			done_s2 <= go_s1;
		end
	end

	assign out_valid  = done_s2;
	assign out_status = status_s2;
	assign out_score  = score_s2;

endmodule
`default_nettype wire

FILE: hw/rtl/weighted_stale_aware_status_vote_core.sv
// weighted_stale_aware_status_vote_core: top level, configuration registers and sequencer
// a report transfer starts two read sweeps of the four-entry report memory (one entry per cycle)
// and then the decide stage; a new report is taken only after the result strobe
// busy from the transfer until the result cycle; the receiver cannot stall
// reset: arst_n clears registers to their defaults, all entries read invalid at time zero
// depends on wsv_pkg, wsv_store, wsv_accum, wsv_decide
`timescale 1ns / 1ps
`default_nettype none
module weighted_stale_aware_status_vote_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [wsv_pkg::SLOT_W-1:0]     detector_index,
	input  wire logic [wsv_pkg::STATUS_W-1:0]   reported_status,
	input  wire logic [wsv_pkg::TIME_W-1:0]     report_time,
	output logic                                done,
	output logic [wsv_pkg::STATUS_W-1:0]        fused_status,
	output logic [wsv_pkg::SCORE_W-1:0]         top_score,
	output logic                                report_rejected,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wsv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wsv_pkg::CFG_DAT_W-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DEC   = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [3:0]                       step_q;
	logic                             rej_q;
	logic                             lat_s1;
	logic                             scr_s1;
	logic [wsv_pkg::SLOT_W-1:0]       slot_s1;

	logic [wsv_pkg::NUM_DET-1:0]      mask_q;
	wsv_pkg::weights_t                weights_q;
	wsv_pkg::stale_t                  stale_q;

	logic                             accept;
	logic                             slot_ok;
	logic                             rd_en;
	wsv_pkg::entry_t                  wr_data;
	wsv_pkg::entry_t                  rd_data;
	wsv_pkg::acc_ctl_t                ctl;
	wsv_pkg::scores_t                 scores;
	wsv_pkg::voted_t                  voted;
	logic                             dec_go;
	logic                             dec_valid;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign slot_ok   = mask_q[detector_index];
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			weights_q <= wsv_pkg::WEIGHTS_RST;
			stale_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wsv_pkg::REG_MASK:    mask_q     <= cfg_data[wsv_pkg::NUM_DET-1:0];
				wsv_pkg::REG_WEIGHTS: weights_q  <= cfg_data;
				wsv_pkg::REG_STALE_0: stale_q[0] <= cfg_data[wsv_pkg::TIME_W-1:0];
				wsv_pkg::REG_STALE_1: stale_q[1] <= cfg_data[wsv_pkg::TIME_W-1:0];
				wsv_pkg::REG_STALE_2: stale_q[2] <= cfg_data[wsv_pkg::TIME_W-1:0];
				wsv_pkg::REG_STALE_3: stale_q[3] <= cfg_data[wsv_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: eight reads, first four for latest time, last four for scoring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			rej_q   <= 1'b0;
			lat_s1  <= 1'b0;
			scr_s1  <= 1'b0;
			slot_s1 <= '0;
		end else begin
			lat_s1  <= rd_en && !step_q[2];
			scr_s1  <= rd_en && step_q[2];
			slot_s1 <= step_q[1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						rej_q   <= !slot_ok;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 4'd1;
					if (step_q[3]) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (dec_valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rd_en  = (state_q == ST_RUN) && !step_q[3];
	assign dec_go = (state_q == ST_DEC);

	assign wr_data.status = reported_status;
	assign wr_data.stamp  = report_time;

	assign ctl.clr        = accept;
	assign ctl.upd_latest = lat_s1;
	assign ctl.upd_score  = scr_s1;
	assign ctl.slot       = slot_s1;

	wsv_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && slot_ok),
		.wr_addr (detector_index),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (step_q[1:0]),
		.rd_data (rd_data)
	);

	wsv_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.rd_data     (rd_data),
		.enable_mask (mask_q),
		.weights     (weights_q),
		.stale_limit (stale_q),
		.scores      (scores),
		.voted       (voted)
	);

	wsv_decide u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (dec_go),
		.scores     (scores),
		.voted      (voted),
		.out_valid  (dec_valid),
		.out_status (fused_status),
		.out_score  (top_score)
	);

	assign done            = dec_valid;
	assign report_rejected = rej_q;

`ifndef SYNTHESIS
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_DRAIN))
		else $error("result strobe outside drain state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && (step_q == 4'd0)))
		else $error("sequencer did not start after transfer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (fused_status == wsv_pkg::STAT_INVALID)) |-> (top_score == '0))
		else $error("invalid result with non-zero score");
`endif

endmodule
`default_nettype wire
